// File: rtl/prp_pkg.sv
// shared types and constants for the point rotation pipeline
package prp_pkg;

    // whole-degree conversion: 180/pi = 57 + DEG_FRAC / 2^32
    localparam logic [31:0] DEG_WHOLE  = 32'd57;
    localparam logic [31:0] DEG_FRAC   = 32'd1270363336;

    // binary-angle conversion: 2^32/(2*pi) = TURN_WHOLE + TURN_FRAC / 2^16
    localparam logic [31:0] TURN_WHOLE = 32'd683565275;
    localparam logic [31:0] TURN_FRAC  = 32'd37777;

    // exact floor(n/360) for n < 2^31 is (n * RECIP_360) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_360   = 32'd3054198967;
    localparam int          RECIP_SHIFT = 40;
    localparam logic [31:0] ROT_FULL    = 32'd360;

    // angle / vector datapath widths
    localparam int DEG_W = 31;
    localparam int Q_W   = 23;
    localparam int XY_W  = 33;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam int MAX_STEPS = 30;

    localparam logic [31:0] ATAN_TURNS [0:MAX_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5339245,   32'd2669640,  32'd1334824,
        32'd667412,    32'd333706,    32'd166853,    32'd83426,    32'd41713,
        32'd20856,     32'd10428,     32'd5214,      32'd2607,     32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
        32'd20,        32'd10,        32'd5,         32'd2,        32'd1
    };

    // rotation fixed point: Q28 sine/cosine, half-up rounding
    localparam int ROT_SHIFT = 28;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               skip;
    } item_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
        logic                   flip;
        item_t                  item;
    } cordic_t;

endpackage

// File: rtl/prp_prep.sv
// angle scaling, whole-degree skip test and quadrant fold
module prp_prep #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    output prp_pkg::cordic_t   out_data
);
    import prp_pkg::*;

    logic [4:0] valid_reg;

    // stage 1
    logic [31:0] mag_next;
    logic [31:0] mag_reg;
    logic        neg1_reg;
    item_t       item1_reg;

    // stage 2
    logic [63:0] df_full;
    logic [47:0] tf_full;
    logic [31:0] df_hi_reg;
    logic [37:0] dw_reg;
    logic [31:0] tf_hi_reg;
    logic [61:0] tw_reg;
    logic        neg2_reg;
    item_t       item2_reg;

    // stage 3
    logic [38:0]            deg_sum;
    logic [38:0]            deg_sh;
    logic [62:0]            turn_sum;
    logic [62:0]            turn_sh;
    logic [31:0]            turn_abs;
    logic [31:0]            turn_sgn;
    logic [31:0]            turn_fold;
    logic                   flip_next;
    logic [DEG_W-1:0]       deg3_reg;
    logic signed [XY_W-1:0] z3_reg;
    logic                   flip3_reg;
    item_t                  item3_reg;

    // stage 4
    logic [62:0]            q_full;
    logic [Q_W-1:0]         q4_reg;
    logic [DEG_W-1:0]       deg4_reg;
    logic signed [XY_W-1:0] z4_reg;
    logic                   flip4_reg;
    item_t                  item4_reg;

    // stage 5
    logic    skip_next;
    cordic_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    assign mag_next = angle[31] ? (32'd0 - $unsigned(angle)) : $unsigned(angle);

    assign df_full = 64'(mag_reg) * 64'(DEG_FRAC);
    assign tf_full = 48'(mag_reg) * 48'(TURN_FRAC);

    always_comb
    begin
        deg_sum  = 39'(dw_reg) + 39'(df_hi_reg);
        deg_sh   = deg_sum >> FRAC_BITS;
        turn_sum = 63'(tw_reg) + 63'(tf_hi_reg);
        turn_sh  = turn_sum >> FRAC_BITS;
        turn_abs = turn_sh[31:0];
        turn_sgn = neg2_reg ? (32'd0 - turn_abs) : turn_abs;
        // second and third quadrants: rotate by a half turn, negate later
        flip_next = (turn_sgn[31:30] == 2'b01) || (turn_sgn[31:30] == 2'b10);
        turn_fold = flip_next ? (turn_sgn + 32'h8000_0000) : turn_sgn;
    end

    assign q_full    = 63'(deg3_reg) * 63'(RECIP_360);
    assign skip_next = ((32'(q4_reg) * ROT_FULL) == 32'(deg4_reg));

    always_ff @(posedge clk)
    begin
        mag_reg          <= mag_next;
        neg1_reg         <= angle[31];
        item1_reg.px     <= point_x;
        item1_reg.py     <= point_y;
        item1_reg.cx     <= pivot_x;
        item1_reg.cy     <= pivot_y;
        item1_reg.skip   <= 1'b0;

        df_hi_reg        <= df_full[63:32];
        dw_reg           <= 38'(mag_reg) * 38'(DEG_WHOLE);
        tf_hi_reg        <= tf_full[47:16];
        tw_reg           <= 62'(mag_reg) * 62'(TURN_WHOLE);
        neg2_reg         <= neg1_reg;
        item2_reg        <= item1_reg;

        deg3_reg         <= deg_sh[DEG_W-1:0];
        z3_reg           <= $signed({turn_fold[31], turn_fold});
        flip3_reg        <= flip_next;
        item3_reg        <= item2_reg;

        q4_reg           <= q_full[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        deg4_reg         <= deg3_reg;
        z4_reg           <= z3_reg;
        flip4_reg        <= flip3_reg;
        item4_reg        <= item3_reg;

        out_reg.x         <= CORDIC_GAIN;
        out_reg.y         <= '0;
        out_reg.z         <= z4_reg;
        out_reg.flip      <= flip4_reg;
        out_reg.item.px   <= item4_reg.px;
        out_reg.item.py   <= item4_reg.py;
        out_reg.item.cx   <= item4_reg.cx;
        out_reg.item.cy   <= item4_reg.cy;
        out_reg.item.skip <= skip_next;
    end

    assign out_valid = valid_reg[4];
    assign out_data  = out_reg;

endmodule

// File: rtl/prp_cordic_stage.sv
// one registered cordic micro-rotation
module prp_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  prp_pkg::cordic_t in_data,
    output logic             out_valid,
    output prp_pkg::cordic_t out_data
);
    import prp_pkg::*;

    logic                   valid_reg;
    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] atan;

    always_comb
    begin
        xs        = in_data.x >>> STEP;
        ys        = in_data.y >>> STEP;
        atan      = $signed({1'b0, ATAN_TURNS[STEP]});
        data_next = in_data;
        if (!in_data.z[XY_W-1])
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - atan;
        end
        else
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/prp_rotate.sv
// rotation about the pivot, rounding, saturation and result register
module prp_rotate (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  prp_pkg::cordic_t   in_data,
    output logic               done,
    output logic signed [31:0] rotated_x,
    output logic signed [31:0] rotated_y,
    output logic               skipped
);
    import prp_pkg::*;

    logic [3:0] valid_reg;

    // r1: sine/cosine rounding, offsets
    logic signed [XY_W-1:0] xf;
    logic signed [XY_W-1:0] yf;
    logic signed [XY_W-1:0] c_next;
    logic signed [XY_W-1:0] s_next;
    logic signed [30:0]     c_reg;
    logic signed [30:0]     s_reg;
    logic signed [32:0]     dx_reg;
    logic signed [32:0]     dy_reg;
    item_t                  item1_reg;

    // r2: products
    logic signed [63:0] m_xc_reg;
    logic signed [63:0] m_ys_reg;
    logic signed [63:0] m_xs_reg;
    logic signed [63:0] m_yc_reg;
    item_t              item2_reg;

    // r3: sums
    logic signed [65:0] rx_sum;
    logic signed [65:0] ry_sum;
    logic signed [65:0] rx_shift;
    logic signed [65:0] ry_shift;
    logic signed [37:0] rx_reg;
    logic signed [37:0] ry_reg;
    item_t              item3_reg;

    // r4: saturation
    logic               rx_ovf;
    logic               ry_ovf;
    logic signed [31:0] rx_next;
    logic signed [31:0] ry_next;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic               out_skip_reg;

    localparam logic signed [65:0] HALF_LSB = 66'sd134217728;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        xf     = in_data.flip ? -in_data.x : in_data.x;
        yf     = in_data.flip ? -in_data.y : in_data.y;
        c_next = (xf + 33'sd2) >>> 2;
        s_next = (yf + 33'sd2) >>> 2;
    end

    always_comb
    begin
        rx_sum   = 66'(m_xc_reg) - 66'(m_ys_reg)
                 + (66'(item2_reg.cx) <<< ROT_SHIFT) + HALF_LSB;
        ry_sum   = 66'(m_xs_reg) + 66'(m_yc_reg)
                 + (66'(item2_reg.cy) <<< ROT_SHIFT) + HALF_LSB;
        rx_shift = rx_sum >>> ROT_SHIFT;
        ry_shift = ry_sum >>> ROT_SHIFT;
    end

    always_comb
    begin
        // out of range when the bits above the sign do not all match it
        rx_ovf  = !((&rx_reg[37:31]) || (~|rx_reg[37:31]));
        ry_ovf  = !((&ry_reg[37:31]) || (~|ry_reg[37:31]));
        rx_next = rx_ovf ? (rx_reg[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : rx_reg[31:0];
        ry_next = ry_ovf ? (ry_reg[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : ry_reg[31:0];
        if (item3_reg.skip)
        begin
            rx_next = item3_reg.px;
            ry_next = item3_reg.py;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next[30:0];
        s_reg        <= s_next[30:0];
        dx_reg       <= 33'(in_data.item.px) - 33'(in_data.item.cx);
        dy_reg       <= 33'(in_data.item.py) - 33'(in_data.item.cy);
        item1_reg    <= in_data.item;

        m_xc_reg     <= 64'(dx_reg) * 64'(c_reg);
        m_ys_reg     <= 64'(dy_reg) * 64'(s_reg);
        m_xs_reg     <= 64'(dx_reg) * 64'(s_reg);
        m_yc_reg     <= 64'(dy_reg) * 64'(c_reg);
        item2_reg    <= item1_reg;

        rx_reg       <= rx_shift[37:0];
        ry_reg       <= ry_shift[37:0];
        item3_reg    <= item2_reg;

        out_x_reg    <= rx_next;
        out_y_reg    <= ry_next;
        out_skip_reg <= item3_reg.skip;
    end

    assign done      = valid_reg[3];
    assign rotated_x = out_x_reg;
    assign rotated_y = out_y_reg;
    assign skipped   = out_skip_reg;

endmodule

// File: rtl/point_rotate_about_pivot.sv
// top level: rotates a Q16.16 point about a pivot by an angle in radians
//
// input: drive point_x, point_y, pivot_x, pivot_y and angle with start high;
// the transfer happens at a rising edge where start is high and busy is low.
// busy never rises: the datapath is a free-running pipeline, so a new item
// may be started on every clock edge.
// output: each item gives one result, shown on rotated_x, rotated_y and
// skipped for exactly one cycle while done is high; results come out in the
// order the items went in.
// pipeline: after the transfer edge an item passes five stages of angle
// scaling and skip test, one stage per cordic step and four stages of
// rotation and saturation, the last of which is the result register.
// throughput: one item per cycle.
// skipped is high when the truncated whole-degree angle is a multiple of
// 360; the point then passes through unchanged.
// reset: rst_n clears all valid bits at once; no result follows reset
// until a new item is started. the receiver cannot stall the block.
module point_rotate_about_pivot #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] rotated_x,
    output logic signed [31:0] rotated_y,
    output logic               skipped
);
    import prp_pkg::*;

    localparam int N_STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    logic [N_STEPS:0] stg_v;
    cordic_t          stg_d [N_STEPS+1];

    assign busy = 1'b0;

    prp_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .pivot_x   (pivot_x),
        .pivot_y   (pivot_y),
        .angle     (angle),
        .out_valid (stg_v[0]),
        .out_data  (stg_d[0])
    );

    for (genvar g = 0; g < N_STEPS; g++)
    begin : g_cordic
        prp_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_v[g]),
            .in_data   (stg_d[g]),
            .out_valid (stg_v[g+1]),
            .out_data  (stg_d[g+1])
        );
    end

    prp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_v[N_STEPS]),
        .in_data   (stg_d[N_STEPS]),
        .done      (done),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .skipped   (skipped)
    );

endmodule

// File: sim/point_rotate_about_pivot_tb.sv
`timescale 1ns / 1ps
// testbench for point_rotate_about_pivot: directed and random points checked against a predictor
module point_rotate_about_pivot_tb;

    localparam int STEPS       = 16;
    localparam int FRAC        = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = STEPS + 30;

    localparam logic [63:0] DEG_WHOLE_C  = 64'd57;
    localparam logic [63:0] DEG_FRAC_C   = 64'd1270363336;
    localparam logic [63:0] TURN_WHOLE_C = 64'd683565275;
    localparam logic [63:0] TURN_FRAC_C  = 64'd37777;
    localparam longint      GAIN_Q30     = 64'sd652032874;

    // common angles in Q16.16 radians
    localparam int ONE_DEGREE   = 1144;
    localparam int HALF_PI      = 102944;
    localparam int PI_Q16       = 205887;
    localparam int THREE_HALVES = 308831;
    localparam int TWO_PI       = 411775;

    localparam logic signed [31:0] MAX_Q = 32'sh7fff_ffff;
    localparam logic signed [31:0] MIN_Q = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               skip;
    } rotation_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] angle;
    logic               done;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic               skipped;

    rotation_t pending_points [$];
    longint    atan_tab [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5339245, 2669640, 1334824, 667412, 333706, 166853, 83426,
        41713, 20856, 10428, 5214, 2607, 1303, 651, 325, 162, 81, 40, 20, 10,
        5, 2, 1
    };

    int error_count;
    int sent_count;
    int rotated_count;
    int skipped_count;

    point_rotate_about_pivot #(
        .CORDIC_STEPS(STEPS),
        .FRAC_BITS   (FRAC)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .point_x  (point_x),
        .point_y  (point_y),
        .pivot_x  (pivot_x),
        .pivot_y  (pivot_y),
        .angle    (angle),
        .done     (done),
        .rotated_x(rotated_x),
        .rotated_y(rotated_y),
        .skipped  (skipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return MAX_Q;
        if (v < -64'sd2147483648)
            return MIN_Q;
        return v[31:0];
    endfunction

    function automatic rotation_t rotate_point(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] cx,
                                               input logic signed [31:0] cy,
                                               input logic signed [31:0] ang);
        rotation_t   res;
        logic [63:0] mag;
        logic [63:0] deg;
        logic [63:0] turn_wide;
        logic [31:0] turn;
        logic        flip;
        longint      z, x, y, xs, ys, c, s, dx, dy, rx, ry;
        int          n;
        mag = (ang < 0) ? 64'(-longint'(ang)) : 64'(longint'(ang));
        deg = (mag * DEG_WHOLE_C + ((mag * DEG_FRAC_C) >> 32)) >> FRAC;
        if (deg % 64'd360 == 64'd0)
        begin
            res.x    = px;
            res.y    = py;
            res.skip = 1'b1;
            return res;
        end
        turn_wide = (mag * TURN_WHOLE_C + ((mag * TURN_FRAC_C) >> 16)) >> FRAC;
        turn = turn_wide[31:0];
        if (ang < 0)
            turn = 32'd0 - turn;
        // fold the second and third quadrants by a half turn
        flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
        if (flip)
            turn = turn + 32'h8000_0000;
        z = longint'($signed(turn));
        x = GAIN_Q30;
        y = 0;
        n = (STEPS < 30) ? STEPS : 30;
        for (int i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c  = (x + 2) >>> 2;
        s  = (y + 2) >>> 2;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        rx = dx * c - dy * s + (longint'(cx) <<< 28) + 64'sd134217728;
        ry = dx * s + dy * c + (longint'(cy) <<< 28) + 64'sd134217728;
        res.x    = clamp_q16(rx >>> 28);
        res.y    = clamp_q16(ry >>> 28);
        res.skip = 1'b0;
        return res;
    endfunction

    // each result is checked against the oldest pending prediction
    always @(posedge clk)
    begin
        rotation_t exp_r;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result with no pending transfer: x=%0d y=%0d skipped=%0b",
                       rotated_x, rotated_y, skipped);
                error_count++;
            end
            else
            begin
                exp_r = pending_points.pop_front();
                if (rotated_x !== exp_r.x)
                begin
                    $error("rotated_x: expected %0d, got %0d", exp_r.x, rotated_x);
                    error_count++;
                end
                if (rotated_y !== exp_r.y)
                begin
                    $error("rotated_y: expected %0d, got %0d", exp_r.y, rotated_y);
                    error_count++;
                end
                if (skipped !== exp_r.skip)
                begin
                    $error("skipped: expected %0b, got %0b", exp_r.skip, skipped);
                    error_count++;
                end
                if (exp_r.skip)
                    skipped_count++;
                else
                    rotated_count++;
            end
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy && rst_n) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("point_rotate_about_pivot_tb: FAIL");
        $finish;
    end

    task automatic transfer_point(input logic signed [31:0] px,
                                  input logic signed [31:0] py,
                                  input logic signed [31:0] cx,
                                  input logic signed [31:0] cy,
                                  input logic signed [31:0] ang);
        point_x <= px;
        point_y <= py;
        pivot_x <= cx;
        pivot_y <= cy;
        angle   <= ang;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_points.push_back(rotate_point(px, py, cx, cy, ang));
        sent_count++;
    endtask

    task automatic hold_off(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 32'h0020_0000) - 32'sh0010_0000;
            1:       return MAX_Q - $urandom_range(0, 4096);
            2:       return MIN_Q + $urandom_range(0, 4096);
            3:       return $urandom_range(0, 32'h0000_8000) - 32'sh0000_4000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] random_angle();
        int k;
        int m;
        case ($urandom_range(0, 5))
            0:
            begin
                // around whole turns, where the skip rule decides
                k = $urandom_range(0, 5200);
                m = k * TWO_PI + int'($urandom_range(0, 2000)) - 700;
                if (m < 0)
                    m = -m;
                return $urandom_range(0, 1) ? -m : m;
            end
            1:       return $urandom_range(0, 2 * ONE_DEGREE) - ONE_DEGREE;
            2:       return $urandom_range(0, 8 * TWO_PI) - 4 * TWO_PI;
            3:       return ($urandom_range(0, 7) * HALF_PI) * ($urandom_range(0, 1) ? -1 : 1)
                            + int'($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_skip_rule();
        transfer_point(32'sh0001_0000, 32'sh0002_0000, 0, 0, 0);
        transfer_point(32'sh0003_0000, -32'sh0001_0000, 32'sh0001_0000, 0, ONE_DEGREE - 1);
        transfer_point(-32'sh0003_0000, 32'sh0005_0000, 0, 32'sh0001_0000, 1 - ONE_DEGREE);
        transfer_point(32'sh0001_0000, 0, 0, 0, ONE_DEGREE);
        transfer_point(32'sh0001_0000, 0, 0, 0, TWO_PI);
        transfer_point(32'sh0001_0000, 0, 0, 0, -TWO_PI);
        transfer_point(32'sh0001_0000, 0, 0, 0, TWO_PI - ONE_DEGREE);
        transfer_point(32'sh0001_0000, 0, 0, 0, 2 * TWO_PI + 500);
        drain_results();
    endtask

    task automatic test_quadrants();
        transfer_point(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, HALF_PI);
        hold_off(50);
        transfer_point(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, PI_Q16);
        transfer_point(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, -HALF_PI);
        hold_off(50);
        transfer_point(32'sh0002_0000, 32'sh0001_0000, 0, 0, THREE_HALVES);
        transfer_point(32'sh0002_0000, 32'sh0001_0000, 0, 0, -PI_Q16);
        transfer_point(32'sh0000_8000, -32'sh0000_8000, 0, 0, MAX_Q);
        transfer_point(32'sh0000_8000, -32'sh0000_8000, 0, 0, MIN_Q);
        drain_results();
    endtask

    task automatic test_coordinate_extremes();
        // huge offsets and saturation in both directions
        transfer_point(MAX_Q, MAX_Q, MIN_Q, MIN_Q, PI_Q16);
        transfer_point(MIN_Q, MIN_Q, MAX_Q, MAX_Q, PI_Q16);
        transfer_point(MAX_Q, MIN_Q, MIN_Q, MAX_Q, HALF_PI);
        transfer_point(MAX_Q, 0, 0, 0, HALF_PI);
        transfer_point(MIN_Q, MAX_Q, MIN_Q, MAX_Q, 12345);
        transfer_point(MAX_Q, MAX_Q, MAX_Q, MAX_Q, -54321);
        transfer_point(32'shffff_ffff, 32'sh0000_0001, 0, 0, MIN_Q);
        transfer_point(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MAX_Q);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count);
        int idle_pct;
        idle_pct = 0;
        for (int i = 0; i < count; i++)
        begin
            // alternate stretches of gapped and back-to-back transfers
            if (i % 40 == 0)
                idle_pct = $urandom_range(0, 1) ? 35 : 0;
            if (i == count / 2)
                drain_results();
            transfer_point(random_coord(), random_coord(), random_coord(), random_coord(),
                           random_angle());
            hold_off(idle_pct);
        end
    endtask

    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++)
            transfer_point(random_coord(), random_coord(), random_coord(), random_coord(),
                           random_angle());
    endtask

    initial
    begin
        error_count   = 0;
        sent_count    = 0;
        rotated_count = 0;
        skipped_count = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        point_x <= '0;
        point_y <= '0;
        pivot_x <= '0;
        pivot_y <= '0;
        angle   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_skip_rule();
        test_quadrants();
        test_coordinate_extremes();
        test_random_traffic(800);
        test_back_to_back(130);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d transfers: %0d rotated, %0d passed through on the skip rule",
                 sent_count, rotated_count, skipped_count);
        $display("angles spanned whole turns, quadrants and full range, with gapped and %s",
                 "back-to-back traffic");
        if (error_count == 0)
            $display("point_rotate_about_pivot_tb: PASS");
        else
            $display("point_rotate_about_pivot_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/prp_pkg.sv
rtl/prp_prep.sv
rtl/prp_cordic_stage.sv
rtl/prp_rotate.sv
rtl/point_rotate_about_pivot.sv
sim/point_rotate_about_pivot_tb.sv
